[rtl/dhq_pkg.sv]
// Shared types and codes for the d-ary min-heap queue unit.
// No dependencies; used by rtl/d_ary_min_heap_queue_unit.sv.
`default_nettype none

package dhq_pkg;

	// request kinds (tuser on the request side)
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	// result status (tuser on the result side)
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// arity register
	localparam logic [3:0] ARITY_MIN   = 4'd2;
	localparam logic [3:0] ARITY_MAX   = 4'd8;
	localparam logic [3:0] ARITY_RESET = 4'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP,
		ST_UP_Q,
		ST_UP_CMP,
		ST_DN_LAST,
		ST_DN,
		ST_DN_RD,
		ST_DN_END,
		ST_DONE
	} st_t;

endpackage

`default_nettype wire

[rtl/d_ary_min_heap_queue_unit.sv]
// d-ary min-heap priority queue: FSM, heap memory and result register.
// Depends on rtl/dhq_pkg.sv.
//
//  channel   dir   handshake            payload
//  s_*       in    s_tvalid/s_tready    s_tdata: value; s_tuser: req_type
//  m_*       out   m_tvalid/m_tready    m_tdata: min_value, count, is_empty; m_tuser: status
//  cfg_*     in    cfg_valid/cfg_ready  cfg_data: arity
//
// One request at a time; a query, a dropped request or a pop down to empty goes straight
// to the result. Insert moves the key up past each larger parent, one parent at a time.
// Pop moves the last entry to the root and sifts it down, reading each level's children
// one at a time through the single read port.
// Reset clears count, state and result valid and resets arity; heap memory is not cleared.
// A result waiting in the output register does not stop the next request being accepted.
`default_nettype none

module d_ary_min_heap_queue_unit #(
	parameter int CAPACITY  = 1024,
	parameter int KEY_WIDTH = 32
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      s_tvalid,
	output logic                                     s_tready,
	input  wire  [31:0]                              s_tdata,  // [31:0] value
	input  wire  [1:0]                               s_tuser,  // [1:0] req_type
	output logic                                     m_tvalid,
	input  wire                                      m_tready,
	// [31:0] min_value, then count, then is_empty, zero padded to bytes
	output logic [((32 + $clog2(CAPACITY + 1) + 1 + 7) / 8) * 8 - 1:0] m_tdata,
	output logic [1:0]                               m_tuser,  // [1:0] status
	input  wire                                      cfg_valid,
	output logic                                     cfg_ready,
	input  wire  [3:0]                               cfg_data  // [3:0] arity
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int EW    = AW + 4;
	localparam int RK    = AW + 1;
	localparam int PW    = AW + RK;
	localparam int OBITS = 32 + CW + 1;
	localparam int OW    = ((OBITS + 7) / 8) * 8;

	localparam logic [RK-1:0] RCP2 = RK'((2 ** RK) / 2);
	localparam logic [RK-1:0] RCP3 = RK'((2 ** RK) / 3);
	localparam logic [RK-1:0] RCP4 = RK'((2 ** RK) / 4);
	localparam logic [RK-1:0] RCP5 = RK'((2 ** RK) / 5);
	localparam logic [RK-1:0] RCP6 = RK'((2 ** RK) / 6);
	localparam logic [RK-1:0] RCP7 = RK'((2 ** RK) / 7);
	localparam logic [RK-1:0] RCP8 = RK'((2 ** RK) / 8);

	dhq_pkg::st_t state_q, state_d;

	logic [3:0]                  arity_q;
	logic [CW-1:0]               cnt_q;
	logic [AW-1:0]               pos_q;
	logic [AW-1:0]               par_q;
	logic [AW-1:0]               nm1_q;
	logic [PW-1:0]               prod_q;
	logic [AW-1:0]               c_q;
	logic [AW-1:0]               hi_q;
	logic [AW-1:0]               best_idx_q;
	logic signed [KEY_WIDTH-1:0] best_val_q;
	logic signed [KEY_WIDTH-1:0] key_q;
	logic signed [KEY_WIDTH-1:0] root_q;
	logic [1:0]                  status_q;
	logic                        rd_vld_s1;

	logic                        m_valid_q;
	logic signed [31:0]          out_min_q;
	logic [CW-1:0]               out_cnt_q;
	logic                        out_empty_q;
	logic [1:0]                  out_stat_q;

	// heap memory
	logic signed [KEY_WIDTH-1:0] mem [CAPACITY];
	logic signed [KEY_WIDTH-1:0] mem_rdata_q;
	logic                        mem_we, mem_re;
	logic [AW-1:0]               mem_waddr, mem_raddr;
	logic signed [KEY_WIDTH-1:0] mem_wdata;

	logic                        accept, out_free, is_full, is_zero;
	logic [3:0]                  d_eff;
	logic [RK-1:0]               rcp_d;
	logic signed [KEY_WIDTH-1:0] key_in;
	logic [AW-1:0]               up_nm1;
	logic [AW-1:0]               q_est;
	logic [EW-1:0]               q_rem;
	logic [AW-1:0]               parent;
	logic                        up_less;
	logic [EW-1:0]               dn_base, dn_lo, dn_hi, cnt_m1, dn_hi_lim;
	logic                        dn_leaf;
	logic                        take_c;
	logic signed [KEY_WIDTH-1:0] win_val;
	logic [AW-1:0]               win_idx;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign is_full   = (cnt_q == CW'(CAPACITY));
	assign is_zero   = (cnt_q == '0);
	assign cfg_ready = 1'b1;
	assign key_in    = KEY_WIDTH'($signed(s_tdata));

	always_comb begin
		if (arity_q < dhq_pkg::ARITY_MIN) begin
			d_eff = dhq_pkg::ARITY_MIN;
		end else if (arity_q > dhq_pkg::ARITY_MAX) begin
			d_eff = dhq_pkg::ARITY_MAX;
		end else begin
			d_eff = arity_q;
		end
	end

	always_comb begin
		case (d_eff)
			4'd2:    rcp_d = RCP2;
			4'd3:    rcp_d = RCP3;
			4'd4:    rcp_d = RCP4;
			4'd5:    rcp_d = RCP5;
			4'd6:    rcp_d = RCP6;
			4'd7:    rcp_d = RCP7;
			default: rcp_d = RCP8;
		endcase
	end

	// parent = (pos-1)/d by reciprocal; the estimate is low by at most one
	assign up_nm1 = pos_q - AW'(1);
	assign q_est  = prod_q[PW-1:RK];
	assign q_rem  = EW'(nm1_q) - EW'(q_est) * EW'(d_eff);
	assign parent = (q_rem >= EW'(d_eff)) ? q_est + AW'(1) : q_est;
	assign up_less = (key_q < mem_rdata_q);

	// children of pos sit at d*pos+1 .. d*pos+d
	assign dn_base   = EW'(pos_q) * EW'(d_eff);
	assign dn_lo     = dn_base + EW'(1);
	assign dn_hi     = dn_base + EW'(d_eff);
	assign cnt_m1    = EW'(cnt_q) - EW'(1);
	assign dn_hi_lim = (dn_hi < cnt_m1) ? dn_hi : cnt_m1;
	assign dn_leaf   = (dn_lo >= EW'(cnt_q));

	// strict less keeps the lowest index on a tie
	assign take_c  = rd_vld_s1 && (mem_rdata_q < best_val_q);
	assign win_val = take_c ? mem_rdata_q : best_val_q;
	assign win_idx = take_c ? c_q - AW'(1) : best_idx_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			dhq_pkg::ST_IDLE: begin
				if (accept) begin
					case (s_tuser)
						dhq_pkg::REQ_INSERT: state_d = is_full ? dhq_pkg::ST_DONE
						                                       : dhq_pkg::ST_UP;
						dhq_pkg::REQ_POP: begin
							if (cnt_q > CW'(1)) begin
								state_d = dhq_pkg::ST_DN_LAST;
							end else begin
								state_d = dhq_pkg::ST_DONE;
							end
						end
						default: state_d = dhq_pkg::ST_DONE;
					endcase
				end
			end
			dhq_pkg::ST_UP:      state_d = (pos_q == '0) ? dhq_pkg::ST_DONE : dhq_pkg::ST_UP_Q;
			dhq_pkg::ST_UP_Q:    state_d = dhq_pkg::ST_UP_CMP;
			dhq_pkg::ST_UP_CMP:  state_d = up_less ? dhq_pkg::ST_UP : dhq_pkg::ST_DONE;
			dhq_pkg::ST_DN_LAST: state_d = dhq_pkg::ST_DN;
			dhq_pkg::ST_DN:      state_d = dn_leaf ? dhq_pkg::ST_DONE : dhq_pkg::ST_DN_RD;
			dhq_pkg::ST_DN_RD:   state_d = (c_q == hi_q) ? dhq_pkg::ST_DN_END : dhq_pkg::ST_DN_RD;
			dhq_pkg::ST_DN_END:  state_d = (win_idx == pos_q) ? dhq_pkg::ST_DONE : dhq_pkg::ST_DN;
			dhq_pkg::ST_DONE:    state_d = out_free ? dhq_pkg::ST_IDLE : dhq_pkg::ST_DONE;
			default:             state_d = dhq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == dhq_pkg::ST_IDLE);
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = key_q;
		mem_re    = 1'b0;
		mem_raddr = c_q;
		case (state_q)
			dhq_pkg::ST_IDLE: begin
				// fetch the last entry for a pop that leaves entries behind
				if (accept && s_tuser == dhq_pkg::REQ_POP && cnt_q > CW'(1)) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(cnt_q - CW'(1));
				end
			end
			dhq_pkg::ST_UP: begin
				mem_we = (pos_q == '0);
			end
			dhq_pkg::ST_UP_Q: begin
				mem_re    = 1'b1;
				mem_raddr = parent;
			end
			dhq_pkg::ST_UP_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = up_less ? mem_rdata_q : key_q;
			end
			dhq_pkg::ST_DN: begin
				mem_we = dn_leaf;
			end
			dhq_pkg::ST_DN_RD: begin
				mem_re = 1'b1;
			end
			dhq_pkg::ST_DN_END: begin
				mem_we    = 1'b1;
				mem_wdata = (win_idx == pos_q) ? key_q : win_val;
			end
			default: begin
			end
		endcase
	end

	// single write and single read port; the FSM never reads an entry it writes
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dhq_pkg::ST_IDLE;
			arity_q   <= dhq_pkg::ARITY_RESET;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == dhq_pkg::ST_DN_RD);
			if (cfg_valid && cfg_ready) begin
				arity_q <= cfg_data;
			end
			if (accept && s_tuser == dhq_pkg::REQ_INSERT && !is_full) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (accept && s_tuser == dhq_pkg::REQ_POP && !is_zero) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (state_q == dhq_pkg::ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && mem_waddr == '0) begin
			root_q <= mem_wdata;
		end
		case (state_q)
			dhq_pkg::ST_IDLE: begin
				if (accept) begin
					key_q    <= key_in;
					pos_q    <= AW'(cnt_q);
					status_q <= dhq_pkg::STAT_OK;
					if (s_tuser == dhq_pkg::REQ_INSERT && is_full) begin
						status_q <= dhq_pkg::STAT_FULL;
					end
					if (s_tuser == dhq_pkg::REQ_POP && is_zero) begin
						status_q <= dhq_pkg::STAT_EMPTY;
					end
				end
			end
			dhq_pkg::ST_UP: begin
				nm1_q  <= up_nm1;
				prod_q <= PW'(up_nm1) * PW'(rcp_d);
			end
			dhq_pkg::ST_UP_Q: begin
				par_q <= parent;
			end
			dhq_pkg::ST_UP_CMP: begin
				pos_q <= par_q;
			end
			dhq_pkg::ST_DN_LAST: begin
				key_q <= mem_rdata_q;
				pos_q <= '0;
			end
			dhq_pkg::ST_DN: begin
				c_q        <= AW'(dn_lo);
				hi_q       <= AW'(dn_hi_lim);
				best_val_q <= key_q;
				best_idx_q <= pos_q;
			end
			dhq_pkg::ST_DN_RD: begin
				c_q        <= c_q + AW'(1);
				best_val_q <= win_val;
				best_idx_q <= win_idx;
			end
			dhq_pkg::ST_DN_END: begin
				pos_q <= win_idx;
			end
			dhq_pkg::ST_DONE: begin
				if (out_free) begin
					out_min_q   <= is_zero ? 32'sd0 : 32'($signed(root_q));
					out_cnt_q   <= cnt_q;
					out_empty_q <= is_zero;
					out_stat_q  <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tdata  = OW'({out_empty_q, out_cnt_q, out_min_q});

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_re |-> mem_waddr != mem_raddr)
		else $error("heap read and write hit the same entry");

	a_child_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dhq_pkg::ST_DN_RD |-> c_q <= hi_q && EW'(hi_q) < EW'(cnt_q))
		else $error("child read outside the heap");

	a_rd_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> state_q == dhq_pkg::ST_DN_RD || state_q == dhq_pkg::ST_DN_END)
		else $error("child data returned outside a sift-down scan");

	a_full_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && out_stat_q == dhq_pkg::STAT_FULL |-> out_cnt_q == CW'(CAPACITY))
		else $error("full status with room left");

	a_empty_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && out_stat_q == dhq_pkg::STAT_EMPTY |-> out_empty_q && out_cnt_q == '0)
		else $error("empty status on a non-empty heap");

endmodule

`default_nettype wire

[tb/sv/tb_d_ary_min_heap_queue_unit.sv]
// Testbench for d_ary_min_heap_queue_unit: directed table, then random requests over many
// arity settings and a full drain, checked against a heap predictor or fixed table views.
// Depends on rtl/dhq_pkg.sv and rtl/d_ary_min_heap_queue_unit.sv.
`default_nettype none

module tb_d_ary_min_heap_queue_unit;

	localparam int CAPACITY    = 1024;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int MAX_REPORTS = 20;

	// request code 3 is not defined; the block treats it as a query
	localparam logic [1:0] REQ_RESERVED = 2'd3;

	typedef struct packed {
		logic [31:0] min_value;
		logic [10:0] count;
		logic        is_empty;
		logic [1:0]  status;
	} heap_view_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] key;
		logic        typed;
		heap_view_t  want;
	} plan_row_t;

	localparam heap_view_t NO_VIEW   = '0;
	localparam heap_view_t VIEW_IDLE = '{32'h0, 11'd0, 1'b1, dhq_pkg::STAT_OK};
	localparam heap_view_t VIEW_NONE = '{32'h0, 11'd0, 1'b1, dhq_pkg::STAT_EMPTY};

	// directed part, arity at its reset value
	localparam int PLAN_LEN = 22;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{dhq_pkg::REQ_QUERY,  32'h00000000, 1'b1, VIEW_IDLE},
		'{dhq_pkg::REQ_POP,    32'h00001234, 1'b1, VIEW_NONE},
		'{REQ_RESERVED,        32'hFFFFFFFF, 1'b1, VIEW_IDLE},
		'{dhq_pkg::REQ_INSERT, 32'h7FFFFFFF, 1'b1,
			'{32'h7FFFFFFF, 11'd1, 1'b0, dhq_pkg::STAT_OK}},
		'{dhq_pkg::REQ_INSERT, 32'h80000000, 1'b1,
			'{32'h80000000, 11'd2, 1'b0, dhq_pkg::STAT_OK}},
		'{dhq_pkg::REQ_INSERT, 32'h00000000, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_INSERT, 32'hFFFFFFFF, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_INSERT, 32'h80000000, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_INSERT, 32'h00000005, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_INSERT, 32'h00000005, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_INSERT, 32'h80000001, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_QUERY,  32'h5A5A5A5A, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_POP,    32'hDEADBEEF, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_POP,    32'h00000000, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_POP,    32'h00000000, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_POP,    32'hFFFFFFFF, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_POP,    32'h00000000, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_POP,    32'h00000000, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_POP,    32'h00000000, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_POP,    32'h00000000, 1'b0, NO_VIEW},
		'{dhq_pkg::REQ_POP,    32'h00000000, 1'b1, VIEW_NONE},
		'{dhq_pkg::REQ_QUERY,  32'hA5A5A5A5, 1'b1, VIEW_IDLE}
	};

	// arity settings for the random phases, out-of-range values included
	localparam int SETTING_LEN = 11;
	localparam logic [3:0] ARITY_PLAN [SETTING_LEN] = '{
		4'd0, 4'd3, dhq_pkg::ARITY_MAX, 4'd1, 4'd5, 4'd15, 4'd4, 4'd6, 4'd9, 4'd7,
		dhq_pkg::ARITY_MIN
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = dhq_pkg::REQ_QUERY;
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [47:0] m_tdata;  // [31:0] min_value, [42:32] count, [43] is_empty
	wire  [1:0]  m_tuser;  // [1:0] status
	logic        cfg_valid = 1'b0;
	wire         cfg_ready;
	logic [3:0]  cfg_data = '0;

	// heap predictor state
	logic signed [31:0] heap_keys [CAPACITY];
	int                 heap_len;
	logic [3:0]         arity_reg;

	heap_view_t pending_views [$];
	int  mismatches = 0;
	int  sent = 0;
	int  checked = 0;
	int  settings_seen = 0;
	int  peak_len = 0;
	int  full_drops = 0;
	int  empty_pops = 0;
	int  cycles = 0;
	int  stall_left = 0;
	bit  calm = 1'b0;

	d_ary_min_heap_queue_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int fanout();
		if (arity_reg < dhq_pkg::ARITY_MIN) return int'(dhq_pkg::ARITY_MIN);
		if (arity_reg > dhq_pkg::ARITY_MAX) return int'(dhq_pkg::ARITY_MAX);
		return int'(arity_reg);
	endfunction

	function automatic void swap_keys(input int a, input int b);
		logic signed [31:0] t;
		t = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = t;
	endfunction

	// runs one request on the predictor heap and returns what the block should answer
	function automatic heap_view_t apply_request(input logic [1:0] kind, input logic [31:0] key);
		heap_view_t view;
		int d, pos, up, lo, hi, best;
		d = fanout();
		view.status = dhq_pkg::STAT_OK;
		case (kind)
			dhq_pkg::REQ_INSERT: begin
				if (heap_len >= CAPACITY) begin
					view.status = dhq_pkg::STAT_FULL;
					full_drops++;
				end else begin
					heap_keys[heap_len] = key;
					pos = heap_len;
					heap_len++;
					while (pos > 0) begin
						up = (pos - 1) / d;
						if (!(heap_keys[pos] < heap_keys[up])) break;
						swap_keys(pos, up);
						pos = up;
					end
				end
			end
			dhq_pkg::REQ_POP: begin
				if (heap_len == 0) begin
					view.status = dhq_pkg::STAT_EMPTY;
					empty_pops++;
				end else begin
					heap_len--;
					if (heap_len > 0) begin
						heap_keys[0] = heap_keys[heap_len];
						pos = 0;
						forever begin
							lo = d * pos + 1;
							if (lo >= heap_len) break;
							hi = d * pos + d;
							if (hi >= heap_len) hi = heap_len - 1;
							best = pos;
							// strict compare: lowest index keeps a tie
							for (int c = lo; c <= hi; c++)
								if (heap_keys[c] < heap_keys[best]) best = c;
							if (best == pos) break;
							swap_keys(pos, best);
							pos = best;
						end
					end
				end
			end
			default: ;
		endcase
		if (heap_len > peak_len) peak_len = heap_len;
		view.min_value = (heap_len > 0) ? heap_keys[0] : 32'h0;
		view.count     = 11'(heap_len);
		view.is_empty  = (heap_len == 0);
		return view;
	endfunction

	// mostly short gaps, now and then a long one; none in a calm phase
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return $urandom;
		// narrow band gives plenty of ties
		if (r < 85) return 32'(int'($urandom_range(0, 16)) - 8);
		case ($urandom_range(0, 3))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'h00000000;
			default: return 32'hFFFFFFFF;
		endcase
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, checked);
	endtask

	// called at a rising edge; leaves tvalid high at the accepting edge
	task automatic send_request(input logic [1:0] kind, input logic [31:0] key,
			input logic typed, input heap_view_t want);
		int gap;
		heap_view_t view;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= key;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		view = apply_request(kind, key);
		pending_views.insert(pending_views.size(), typed ? want : view);
		sent++;
	endtask

	task automatic send_random(input int insert_pct);
		int r;
		logic [1:0] kind;
		r = $urandom_range(0, 99);
		if (r < insert_pct) kind = dhq_pkg::REQ_INSERT;
		else if (r < 92) kind = dhq_pkg::REQ_POP;
		else if (r < 97) kind = dhq_pkg::REQ_QUERY;
		else kind = REQ_RESERVED;
		send_request(kind, pick_key(), 1'b0, NO_VIEW);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_views.size() != 0) @(posedge clk);
	endtask

	task automatic write_arity(input logic [3:0] setting);
		cfg_valid <= 1'b1;
		cfg_data  <= setting;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		arity_reg = setting;
		settings_seen++;
	endtask

	// result checker and result-side stalls
	always @(posedge clk) begin
		heap_view_t want;
		if (m_tvalid && m_tready) begin
			if (pending_views.size() == 0) begin
				report("result with no request pending", m_tdata[31:0], 32'h0);
			end else begin
				want = pending_views.pop_front();
				if (m_tdata[31:0] !== want.min_value)
					report("min_value", m_tdata[31:0], want.min_value);
				if (m_tdata[42:32] !== want.count)
					report("count", 32'(m_tdata[42:32]), 32'(want.count));
				if (m_tdata[43] !== want.is_empty)
					report("is_empty", 32'(m_tdata[43]), 32'(want.is_empty));
				if (m_tuser !== want.status)
					report("status", 32'(m_tuser), 32'(want.status));
			end
			checked++;
		end
		if (stall_left == 0 && $urandom_range(0, 3) == 0)
			stall_left = pick_gap();
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		heap_len  = 0;
		arity_reg = dhq_pkg::ARITY_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_LEN; i++)
			send_request(PLAN[i].kind, PLAN[i].key, PLAN[i].typed, PLAN[i].want);

		// random phases; the heap is kept across arity changes, no reheapify
		for (int p = 0; p < SETTING_LEN; p++) begin
			int insert_pct;
			wait_idle();
			write_arity(ARITY_PLAN[p]);
			calm = ($urandom_range(0, 3) == 0);
			insert_pct = $urandom_range(30, 70);
			repeat (45) send_random(insert_pct);
		end

		// drain everything under a different fanout, one pop past empty
		wait_idle();
		write_arity(4'd3);
		calm = 1'b0;
		while (heap_len > 0)
			send_request(dhq_pkg::REQ_POP, pick_key(), 1'b0, NO_VIEW);
		send_request(dhq_pkg::REQ_POP, pick_key(), 1'b0, NO_VIEW);

		wait_idle();
		repeat (60) @(posedge clk);

		$display("Ran %0d requests, %0d results checked, %0d arity writes, peak %0d entries",
			sent, checked, settings_seen, peak_len);
		$display("Saw %0d dropped full inserts and %0d ignored empty pops, %0d mismatches",
			full_drops, empty_pops, mismatches);
		if (mismatches == 0 && pending_views.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
